FILE: hdl/mvma_pkg.sv
`default_nettype none
package mvma_pkg;

    // payload widths fixed by the item formats
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 8;
    localparam int ROW_W       = 16;
    localparam int DIM_X_W     = 9;
    localparam int DIM_Y_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int ACC_W       = 64;

    // defaults for the top-level parameters
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_FRAC_BITS   = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BETA  = 2'd3;

    // item kinds
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

endpackage
`default_nettype wire

FILE: hdl/mvma_if.sv
`default_nettype none
interface mvma_in_if import mvma_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [VALUE_W-1:0] value;
    logic        [INDEX_W-1:0] load_index;
    logic signed [VALUE_W-1:0] y_old;

    modport source (output valid, output func, output value, output load_index,
                    output y_old, input ready);
    modport sink   (input valid, input func, input value, input load_index,
                    input y_old, output ready);
endinterface

interface mvma_out_if import mvma_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] y_value;
    logic        [ROW_W-1:0]   row_number;
    logic                      last_row;
    logic                      saturated;

    modport source (output valid, output y_value, output row_number,
                    output last_row, output saturated, input ready);
    modport sink   (input valid, input y_value, input row_number,
                    input last_row, input saturated, output ready);
endinterface
`default_nettype wire

FILE: hdl/matrix_vector_multiply_accumulate.sv
`default_nettype none
// y = beta*y + alpha*A*x in signed fixed point (FRAC_BITS fraction bits)
// in_item : valid/ready stream; func = load puts value into the vector store at
//           load_index (ignored at MAX_COLUMNS or above); func = matrix is one element
//           of A in row-major order, y_old is used on the last column of a row
// out_item: valid/ready stream, one transfer per finished row with the new y,
//           its row number, a last-row mark and a saturation flag
// cfg     : write-only port (cfg_we, cfg_index, cfg_data); write only when idle
// steps   : a load is taken in the idle state; a matrix element passes through
//           store read, multiply, round and accumulate on the one shared 32x32
//           multiplier, and no new item is taken until it is back in idle; the
//           last element of a row goes on through clip sum, alpha product, beta
//           product, add, and round and clip; the result is visible the cycle after
// stall   : the result sits in an output register; new items are still taken
//           while it waits, and only the next row end holds until it is taken
// reset   : rst_n clears the row sum, counters, flags and sets the registers
//           to dim_x = 1, dim_y = 1, alpha = 65536 (1.0 when FRAC_BITS = 16),
//           beta = 0; the vector store is not cleared and must be loaded before use
module matrix_vector_multiply_accumulate import mvma_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    mvma_in_if.sink                     in_item,
    mvma_out_if.source                  out_item
);

    // store geometry
    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int CAP    = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam int HALF_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic signed [ACC_W-1:0] HALF =
        (FRAC_BITS > 0) ? (ACC_W'(1) << HALF_SH) : '0;
    localparam logic signed [ACC_W-1:0] MAX64 = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN64 = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] MIN32 = -ACC_W'(64'sh8000_0000);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_RND  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_SAT  = 4'd4;
    localparam logic [3:0] S_MULA = 4'd5;
    localparam logic [3:0] S_MULB = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // saturating 64-bit add, clip flag in the top bit
    function automatic logic [ACC_W:0] sat_add(logic signed [ACC_W-1:0] a,
                                               logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        logic                    ovf;
        s   = a + b;
        ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
        if (ovf)
            return {1'b1, (a[ACC_W-1] ? MIN64 : MAX64)};
        return {1'b0, s};
    endfunction

    // clip to the 32-bit signed range, kept sign-extended
    function automatic logic [ACC_W:0] sat32(logic signed [ACC_W-1:0] v);
        if (v > MAX32)
            return {1'b1, MAX32};
        if (v < MIN32)
            return {1'b1, MIN32};
        return {1'b0, v};
    endfunction

    // configuration registers
    logic        [DIM_X_W-1:0] dim_x_reg;
    logic        [DIM_Y_W-1:0] dim_y_reg;
    logic signed [VALUE_W-1:0] alpha_reg;
    logic signed [VALUE_W-1:0] beta_reg;

    // vector store
    logic signed [VALUE_W-1:0] store [MAX_COLUMNS];
    logic signed [VALUE_W-1:0] rd_data_reg;

    // sequencer and row state
    logic [3:0]              state_reg, state_next;
    logic signed [ACC_W-1:0] row_sum_reg, row_sum_next;
    logic [INDEX_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    sum_clip_reg, sum_clip_next;
    logic                    res_clip_reg, res_clip_next;

    // datapath registers, no reset needed
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] y_old_reg;
    logic signed [ACC_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] y_value_reg, y_value_next;
    logic        [ROW_W-1:0]   row_number_reg, row_number_next;
    logic                      last_row_reg, last_row_next;
    logic                      saturated_reg, saturated_next;

    // shared multiplier operands
    logic signed [VALUE_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]   mul_res;

    logic                      in_xfer, load_xfer, matrix_xfer;
    logic [EXT_W-1:0]          ld_ext, col_ext;
    logic [ADDR_W-1:0]         ld_addr, col_addr;
    logic                      ld_in_range;
    logic [DIM_X_W-1:0]        eff_x;
    logic [DIM_X_W-1:0]        col_inc;
    logic [ROW_W:0]            row_inc, eff_y;
    logic                      row_is_last;
    logic                      out_free;
    logic [ACC_W:0]            rnd_a, acc_a, sat_a, add_a, rnd_b, sat_b;
    logic signed [ACC_W-1:0]   shifted;

    assign in_item.ready = (state_reg == S_IDLE);
    assign in_xfer       = in_item.valid && in_item.ready;
    assign load_xfer     = in_xfer && (in_item.func == FUNC_LOAD);
    assign matrix_xfer   = in_xfer && (in_item.func == FUNC_MATRIX);

    assign ld_ext      = EXT_W'(in_item.load_index);
    assign ld_addr     = ld_ext[ADDR_W-1:0];
    assign col_ext     = EXT_W'(col_reg);
    assign col_addr    = col_ext[ADDR_W-1:0];
    assign ld_in_range = 32'(in_item.load_index) < 32'(MAX_COLUMNS);

    // effective row length: zero acts as one, capped at the store size and at 256
    always_comb
    begin
        if (dim_x_reg == '0)
            eff_x = DIM_X_W'(1);
        else if (dim_x_reg > DIM_X_W'(CAP))
            eff_x = DIM_X_W'(CAP);
        else
            eff_x = dim_x_reg;
    end

    assign col_inc     = DIM_X_W'(col_reg) + DIM_X_W'(1);
    assign row_inc     = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1);
    assign eff_y       = (dim_y_reg == '0) ? (ROW_W+1)'(1) << ROW_W
                                           : (ROW_W+1)'(dim_y_reg);
    assign row_is_last = row_inc >= eff_y;
    assign out_free    = !out_valid_reg || out_item.ready;

    // one multiplier, operands picked by the sequencer
    always_comb
    begin
        case (state_reg)
            S_MULA:
            begin
                mul_a = alpha_reg;
                mul_b = acc_reg[VALUE_W-1:0];
            end
            S_MULB:
            begin
                mul_a = beta_reg;
                mul_b = y_old_reg;
            end
            default:
            begin
                mul_a = rd_data_reg;
                mul_b = value_reg;
            end
        endcase
    end
    assign mul_res = ACC_W'(mul_a) * ACC_W'(mul_b);

    // rounding of the element product, accumulation, row-end steps
    assign rnd_a   = sat_add(prod_reg, HALF);
    assign acc_a   = sat_add(row_sum_reg, prod_reg);
    assign sat_a   = sat32(row_sum_reg);
    assign add_a   = sat_add(acc_reg, prod_reg);
    assign rnd_b   = sat_add(acc_reg, HALF);
    assign shifted = $signed(rnd_b[ACC_W-1:0]) >>> FRAC_BITS;
    assign sat_b   = sat32(shifted);

    always_comb
    begin
        state_next      = state_reg;
        row_sum_next    = row_sum_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        sum_clip_next   = sum_clip_reg;
        res_clip_next   = res_clip_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_item.ready;
        y_value_next    = y_value_reg;
        row_number_next = row_number_reg;
        last_row_next   = last_row_reg;
        saturated_next  = saturated_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (matrix_xfer)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = mul_res;
                state_next = S_RND;
            end
            S_RND:
            begin
                prod_next     = $signed(rnd_a[ACC_W-1:0]) >>> FRAC_BITS;
                sum_clip_next = sum_clip_reg | rnd_a[ACC_W];
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                row_sum_next  = acc_a[ACC_W-1:0];
                sum_clip_next = sum_clip_reg | acc_a[ACC_W];
                if (col_inc < eff_x)
                begin
                    col_next   = col_inc[INDEX_W-1:0];
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                acc_next      = sat_a[ACC_W-1:0];
                res_clip_next = sum_clip_reg | sat_a[ACC_W];
                state_next    = S_MULA;
            end
            S_MULA:
            begin
                prod_next  = mul_res;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_res;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                acc_next      = add_a[ACC_W-1:0];
                res_clip_next = res_clip_reg | add_a[ACC_W];
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    y_value_next    = sat_b[VALUE_W-1:0];
                    row_number_next = row_reg;
                    last_row_next   = row_is_last;
                    saturated_next  = res_clip_reg | rnd_b[ACC_W] | sat_b[ACC_W];
                    row_next        = row_is_last ? '0 : row_inc[ROW_W-1:0];
                    row_sum_next    = '0;
                    col_next        = '0;
                    sum_clip_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_sum_reg   <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            sum_clip_reg  <= 1'b0;
            res_clip_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dim_x_reg     <= DIM_X_W'(1);
            dim_y_reg     <= DIM_Y_W'(1);
            alpha_reg     <= VALUE_W'(32'sd65536);
            beta_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_sum_reg   <= row_sum_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            sum_clip_reg  <= sum_clip_next;
            res_clip_reg  <= res_clip_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIM_X: dim_x_reg <= cfg_data[DIM_X_W-1:0];
                    CFG_DIM_Y: dim_y_reg <= cfg_data[DIM_Y_W-1:0];
                    CFG_ALPHA: alpha_reg <= cfg_data;
                    CFG_BETA:  beta_reg  <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        y_value_reg    <= y_value_next;
        row_number_reg <= row_number_next;
        last_row_reg   <= last_row_next;
        saturated_reg  <= saturated_next;
        if (matrix_xfer)
        begin
            value_reg <= in_item.value;
            y_old_reg <= in_item.y_old;
        end
    end

    // vector store: one write port, one registered read at the current column
    always_ff @(posedge clk)
    begin
        if (load_xfer && ld_in_range)
            store[ld_addr] <= in_item.value;
        rd_data_reg <= store[col_addr];
    end

    assign out_item.valid      = out_valid_reg;
    assign out_item.y_value    = y_value_reg;
    assign out_item.row_number = row_number_reg;
    assign out_item.last_row   = last_row_reg;
    assign out_item.saturated  = saturated_reg;

endmodule
`default_nettype wire
